>>> hw/rtl/lane_fnv_rotate_hash32_defines.svh
// assertion macros for the lane fnv rotate hash block
// used by lane_fnv_rotate_hash32.sv, no other dependencies
`ifndef LANE_FNV_ROTATE_HASH32_DEFINES_SVH
`define LANE_FNV_ROTATE_HASH32_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LFRH32_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfrh32 check failed");

// next-cycle implication, disabled in reset
`define LFRH32_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfrh32 check failed");

`endif

>>> hw/rtl/lfrh32_pkg.sv
// types, constants and op decode for the lane fnv rotate hash block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfrh32_pkg;

  localparam int unsigned ROT_AMT = 5;
  localparam int unsigned HALF_SHIFT = 16;

  localparam logic [5:0] FULL_CHUNK = 6'd32;
  localparam logic [5:0] TRIAD_CHUNK = 6'd24;

  localparam logic [31:0] SEED_RESET = 32'd2166136261;
  localparam logic [31:0] PRIME_RESET = 32'd709607;

  localparam logic [1:0] CFG_TRIAD = 2'd0;
  localparam logic [1:0] CFG_SEED = 2'd1;
  localparam logic [1:0] CFG_PRIME = 2'd2;

  typedef logic [1:0] lane_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_READ,
    S_MUL
  } state_t;

  typedef enum logic [3:0] {
    OP_MIX0,
    OP_MIX1,
    OP_MIX2,
    OP_MIX3,
    OP_FOLDC,
    OP_FOLDD,
    OP_T16A,
    OP_T16B,
    OP_T8A,
    OP_T8B,
    OP_T4A,
    OP_T4B,
    OP_T2,
    OP_T1,
    OP_FINAL
  } op_t;

  typedef enum logic [2:0] {
    TERM_PAIR,
    TERM_WORD,
    TERM_HALF,
    TERM_BYTE,
    TERM_ROT
  } term_t;

  function automatic logic [31:0] rot5(input logic [31:0] x);
    return (x << ROT_AMT) | (x >> (32 - ROT_AMT));
  endfunction

  function automatic lane_sel_t op_target(input op_t op);
    lane_sel_t t;
    case (op)
      OP_MIX1, OP_FOLDD, OP_T16B, OP_T8B, OP_T4B: t = 2'd1;
      OP_MIX2: t = 2'd2;
      OP_MIX3: t = 2'd3;
      default: t = 2'd0;
    endcase
    return t;
  endfunction

  function automatic lane_sel_t op_src(input op_t op);
    lane_sel_t s;
    case (op)
      OP_FOLDC: s = 2'd2;
      OP_FOLDD: s = 2'd3;
      OP_FINAL: s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic term_t op_term(input op_t op);
    term_t k;
    case (op)
      OP_MIX0, OP_MIX1, OP_MIX2, OP_MIX3, OP_T16A, OP_T16B: k = TERM_PAIR;
      OP_T8A, OP_T8B: k = TERM_WORD;
      OP_T4A, OP_T4B, OP_T2: k = TERM_HALF;
      OP_T1: k = TERM_BYTE;
      default: k = TERM_ROT;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] op_nbytes(input op_t op);
    logic [3:0] n;
    case (op)
      OP_MIX0, OP_MIX1, OP_MIX2, OP_MIX3, OP_T16A, OP_T16B: n = 4'd8;
      OP_T8A, OP_T8B: n = 4'd4;
      OP_T4A, OP_T4B, OP_T2: n = 4'd2;
      OP_T1: n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfrh32_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lfrh32_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfrh32_mix_unit.sv
// shared lane mixing unit: term select, xor and multiply by the prime
// depends on lfrh32_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfrh32_mix_unit
  import lfrh32_pkg::*;
(
  input  wire logic [31:0] lane_val,
  input  wire logic [31:0] src_val,
  input  wire logic [63:0] win,
  input  wire logic [31:0] prime,
  input  wire term_t       kind,
  output logic      [31:0] result
);

  logic [31:0] term;
  logic [31:0] mixed;

  always_comb begin
    case (kind)
      TERM_PAIR: term = rot5(win[31:0]) ^ win[63:32];
      TERM_WORD: term = win[63:32];
      TERM_HALF: term = {16'd0, win[63:48]};
      TERM_BYTE: term = {24'd0, win[63:56]};
      default:   term = rot5(src_val);
    endcase
    mixed = lane_val ^ term;
    result = mixed * prime;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lane_fnv_rotate_hash32.sv
// top level of the lane fnv rotate hash: byte stream in, 32-bit hash out
// depends on lfrh32_pkg, lfrh32_ram, lfrh32_mix_unit, lane_fnv_rotate_hash32_defines.svh
//
//   channel  | side   | payload
//   s_*      | in     | tdata[7:0] data_byte, tuser byte_valid, tlast last
//   m_*      | out    | tdata[31:0] hash
//   cfg_*    | in     | index 0 triad_mode, 1 lane_seed, 2 prime
//
// a byte that does not complete a chunk is stored without leaving S_IDLE
// a full chunk is mixed lane by lane on one shared multiplier, buffer read one byte a cycle
// a last item adds fold and tail steps on the same multiplier
// s_tready is low while a chunk or the finish sequence runs; a held result stalls only the final step
// rst is synchronous, active high; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "lane_fnv_rotate_hash32_defines.svh"

module lane_fnv_rotate_hash32
  import lfrh32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] byte_valid
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] hash
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic        triad_mode;
  logic [31:0] lane_seed;
  logic [31:0] prime;

  state_t      state;
  state_t      state_next;
  op_t         op;
  logic [31:0] lane_a;
  logic [31:0] lane_b;
  logic [31:0] lane_c;
  logic [31:0] lane_d;
  logic [5:0]  fill_count;
  logic        chunk_taken;
  logic        mode_latch;
  logic        fin_pend;
  logic [4:0]  rd_ptr;
  logic [3:0]  issue_left;
  logic [3:0]  recv_left;
  logic        rd_pend;
  logic [63:0] win;
  logic        out_valid;
  logic [31:0] out_hash;

  logic        accept;
  logic        msg_start;
  logic        eff_mode;
  logic [5:0]  chunk_size;
  logic [5:0]  fill_inc;
  logic        chunk_done;
  logic        op_en;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic [31:0] lane_val;
  logic [31:0] src_val;
  logic [31:0] mix_result;
  logic        final_stall;
  lane_sel_t   tgt;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign msg_start = (fill_count == 6'd0) && !chunk_taken;
  assign eff_mode = msg_start ? triad_mode : mode_latch;
  assign chunk_size = eff_mode ? TRIAD_CHUNK : FULL_CHUNK;
  assign fill_inc = fill_count + 6'd1;
  assign chunk_done = s_tuser && (fill_inc >= chunk_size);
  assign ram_re = (state == S_READ) && (issue_left != 4'd0);
  assign final_stall = (op == OP_FINAL) && out_valid && !m_tready;
  assign tgt = op_target(op);
  assign m_tvalid = out_valid;
  assign m_tdata = out_hash;

  always_comb begin
    case (op)
      OP_MIX3:          op_en = !mode_latch;
      OP_FOLDC:         op_en = chunk_taken;
      OP_FOLDD:         op_en = chunk_taken && !mode_latch;
      OP_T16A, OP_T16B: op_en = fill_count[4];
      OP_T8A, OP_T8B:   op_en = fill_count[3];
      OP_T4A, OP_T4B:   op_en = fill_count[2];
      OP_T2:            op_en = fill_count[1];
      OP_T1:            op_en = fill_count[0];
      default:          op_en = 1'b1;
    endcase
  end

  always_comb begin
    case (tgt)
      2'd1:    lane_val = lane_b;
      2'd2:    lane_val = lane_c;
      2'd3:    lane_val = lane_d;
      default: lane_val = lane_a;
    endcase
    case (op_src(op))
      2'd1:    src_val = lane_b;
      2'd2:    src_val = lane_c;
      2'd3:    src_val = lane_d;
      default: src_val = lane_a;
    endcase
  end

  lfrh32_ram #(
    .WIDTH(8),
    .DEPTH(32)
  ) u_chunk_buf (
    .clk  (clk),
    .we   (accept && s_tuser),
    .waddr(fill_count[4:0]),
    .wdata(s_tdata),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  lfrh32_mix_unit u_mix (
    .lane_val(lane_val),
    .src_val (src_val),
    .win     (win),
    .prime   (prime),
    .kind    (op_term(op)),
    .result  (mix_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (chunk_done || s_tlast)) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (op == OP_FOLDC && !fin_pend) begin
          state_next = S_IDLE;
        end else if (op_en) begin
          state_next = (op_nbytes(op) == 4'd0) ? S_MUL : S_READ;
        end
      end
      S_READ: begin
        if (rd_pend && recv_left == 4'd1) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (!final_stall) begin
          state_next = (op == OP_FINAL) ? S_IDLE : S_NEXT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triad_mode <= 1'b0;
      lane_seed <= SEED_RESET;
      prime <= PRIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIAD: triad_mode <= cfg_data[0];
        CFG_SEED:  lane_seed <= cfg_data;
        CFG_PRIME: prime <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_MIX0;
      fill_count <= 6'd0;
      chunk_taken <= 1'b0;
      mode_latch <= 1'b0;
      fin_pend <= 1'b0;
      rd_ptr <= 5'd0;
      issue_left <= 4'd0;
      recv_left <= 4'd0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (out_valid && m_tready && !(state == S_MUL && op == OP_FINAL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg_start) begin
              mode_latch <= triad_mode;
            end
            rd_ptr <= 5'd0;
            fin_pend <= s_tlast;
            if (chunk_done) begin
              fill_count <= 6'd0;
              chunk_taken <= 1'b1;
              op <= OP_MIX0;
            end else begin
              if (s_tuser) begin
                fill_count <= fill_inc;
              end
              op <= OP_FOLDC;
            end
          end
        end
        S_NEXT: begin
          if (op == OP_FOLDC) begin
            rd_ptr <= 5'd0;
          end
          if (!(op == OP_FOLDC && !fin_pend)) begin
            if (op_en) begin
              issue_left <= op_nbytes(op);
              recv_left <= op_nbytes(op);
            end else begin
              op <= op_t'(op + 4'd1);
            end
          end
        end
        S_READ: begin
          if (ram_re) begin
            rd_ptr <= rd_ptr + 5'd1;
            issue_left <= issue_left - 4'd1;
          end
          if (rd_pend) begin
            recv_left <= recv_left - 4'd1;
          end
        end
        S_MUL: begin
          if (!final_stall) begin
            if (op == OP_FINAL) begin
              out_valid <= 1'b1;
              fill_count <= 6'd0;
              chunk_taken <= 1'b0;
              mode_latch <= 1'b0;
              fin_pend <= 1'b0;
            end else begin
              op <= op_t'(op + 4'd1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      win <= {ram_rdata, win[63:8]};
    end
    if (state == S_MUL && !final_stall && op == OP_FINAL) begin
      out_hash <= mix_result ^ (mix_result >> HALF_SHIFT);
    end
    if (accept && msg_start) begin
      lane_a <= lane_seed;
      lane_b <= lane_seed;
      lane_c <= lane_seed;
      lane_d <= lane_seed;
    end else if (state == S_MUL && !final_stall) begin
      case (tgt)
        2'd1:    lane_b <= mix_result;
        2'd2:    lane_c <= mix_result;
        2'd3:    lane_d <= mix_result;
        default: lane_a <= mix_result;
      endcase
    end
  end

  `LFRH32_ASSERT_NOW(a_fill_in_range, clk, rst, 1'b1, fill_count < FULL_CHUNK)
  `LFRH32_ASSERT_NOW(a_triad_fill, clk, rst, mode_latch, fill_count < TRIAD_CHUNK)
  `LFRH32_ASSERT_NOW(a_read_only_in_read, clk, rst, rd_pend, state == S_READ)
  `LFRH32_ASSERT_NEXT(a_last_runs_finish, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

`default_nettype wire

>>> sim/lane_fnv_rotate_hash32_checker.sv
// scoreboard for lane_fnv_rotate_hash32: follows register writes and byte transactions,
// predicts the hash of every message and compares it with each output transaction
// depends on lfrh32_pkg for register indexes, chunk sizes and reset values
`timescale 1ns / 1ps

module lane_fnv_rotate_hash32_checker
  import lfrh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] hash
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned hashes_due
);

  logic        triad_reg;
  logic [31:0] seed_reg;
  logic [31:0] prime_reg;
  logic [31:0] lane [4];
  logic [7:0]  chunk [32];
  logic [5:0]  fill;
  logic        chunk_seen;
  logic        triad_latched;
  logic [31:0] expected_hash_q [$];
  int unsigned fail_tally;

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] times_prime(input logic [31:0] x);
    logic [31:0] prod;
    prod = x * prime_reg;
    return prod;
  endfunction

  // little-endian reads from the chunk
  function automatic logic [31:0] word_at(input logic [4:0] p);
    return {chunk[p + 5'd3], chunk[p + 5'd2], chunk[p + 5'd1], chunk[p]};
  endfunction

  function automatic logic [31:0] half_at(input logic [4:0] p);
    return {16'd0, chunk[p + 5'd1], chunk[p]};
  endfunction

  function automatic logic [31:0] mix_lane(input logic [31:0] v, input logic [4:0] p);
    return times_prime(v ^ rotl5(word_at(p)) ^ word_at(p + 5'd4));
  endfunction

  function automatic logic [31:0] message_hash();
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  p;
    a = lane[0];
    b = lane[1];
    p = 5'd0;
    if (chunk_seen) begin
      a = times_prime(a ^ rotl5(lane[2]));
      if (!triad_latched) b = times_prime(b ^ rotl5(lane[3]));
    end
    if (fill[4]) begin
      a = mix_lane(a, p);
      b = mix_lane(b, p + 5'd8);
      p = p + 5'd16;
    end
    if (fill[3]) begin
      a = times_prime(a ^ word_at(p));
      b = times_prime(b ^ word_at(p + 5'd4));
      p = p + 5'd8;
    end
    if (fill[2]) begin
      a = times_prime(a ^ half_at(p));
      b = times_prime(b ^ half_at(p + 5'd2));
      p = p + 5'd4;
    end
    if (fill[1]) begin
      a = times_prime(a ^ half_at(p));
      p = p + 5'd2;
    end
    if (fill[0]) a = times_prime(a ^ {24'd0, chunk[p]});
    a = times_prime(a ^ rotl5(b));
    return a ^ {16'd0, a[31:16]};
  endfunction

  task automatic absorb_item(input logic [7:0] b, input logic has_byte, input logic is_last);
    if (fill == 6'd0 && !chunk_seen) begin
      for (int i = 0; i < 4; i++) lane[i] = seed_reg;
      triad_latched = triad_reg;
    end
    if (has_byte) begin
      chunk[fill[4:0]] = b;
      fill = fill + 6'd1;
      if (fill >= (triad_latched ? TRIAD_CHUNK : FULL_CHUNK)) begin
        lane[0] = mix_lane(lane[0], 5'd0);
        lane[1] = mix_lane(lane[1], 5'd8);
        lane[2] = mix_lane(lane[2], 5'd16);
        if (!triad_latched) lane[3] = mix_lane(lane[3], 5'd24);
        fill = 6'd0;
        chunk_seen = 1'b1;
      end
    end
    if (is_last) begin
      expected_hash_q.push_back(message_hash());
      fill = 6'd0;
      chunk_seen = 1'b0;
      triad_latched = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      triad_reg = 1'b0;
      seed_reg = SEED_RESET;
      prime_reg = PRIME_RESET;
      fill = 6'd0;
      chunk_seen = 1'b0;
      triad_latched = 1'b0;
      expected_hash_q.delete();
      fail_tally = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIAD: triad_reg = cfg_data[0];
          CFG_SEED: seed_reg = cfg_data;
          CFG_PRIME: prime_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) absorb_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_hash_q.size() == 0) begin
          $error("hash: unexpected transaction, expected none, actual %h", m_tdata);
          fail_tally++;
        end else begin
          want = expected_hash_q.pop_front();
          if (m_tdata !== want) begin
            $error("hash mismatch: expected %h, actual %h", want, m_tdata);
            fail_tally++;
          end
        end
      end
    end
    mismatches <= fail_tally;
    hashes_due <= expected_hash_q.size();
  end

endmodule

>>> sim/tb_lane_fnv_rotate_hash32.sv
// testbench top for lane_fnv_rotate_hash32: drives byte messages and register settings,
// stalls the output at random and reports the verdict from the checker
// depends on lfrh32_pkg, lane_fnv_rotate_hash32 and lane_fnv_rotate_hash32_checker
`timescale 1ns / 1ps

module tb_lane_fnv_rotate_hash32;
  import lfrh32_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] byte_valid
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] hash
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int unsigned mismatches;
  int unsigned hashes_due;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        triad_now;

  always #6 clk = ~clk;

  lane_fnv_rotate_hash32 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lane_fnv_rotate_hash32_checker hash_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .hashes_due(hashes_due)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lane_fnv_rotate_hash32 regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= has_byte;
    s_tlast <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // stray empty items between bytes, sometimes an empty closing item
  task automatic send_message(input int unsigned n_bytes);
    logic empty_end;
    empty_end = (n_bytes == 0) || ($urandom_range(4) == 0);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(11) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, !empty_end && (i == n_bytes - 1));
    end
    if (empty_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic int unsigned message_length(input int unsigned chunk_len);
    int unsigned n;
    case ($urandom_range(9))
      0, 1, 2: n = $urandom_range(31);
      3, 4: n = chunk_len * $urandom_range(1, 3) + $urandom_range(chunk_len - 1);
      5: n = chunk_len * $urandom_range(1, 4);
      6: n = $urandom_range(1);
      7: n = chunk_len * $urandom_range(0, 2) + 16 + $urandom_range(7);
      default: n = $urandom_range(140);
    endcase
    return n;
  endfunction

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at)
      send_message(message_length(32'(triad_now ? TRIAD_CHUNK : FULL_CHUNK)));
  endtask

  // block idle: no hash outstanding and no chunk or finish sequence left running
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hashes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_registers(input logic triad, input logic [31:0] seed,
                                input logic [31:0] prime);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRIAD;
    cfg_data <= {31'd0, triad};
    @(posedge clk);
    cfg_index <= CFG_SEED;
    cfg_data <= seed;
    @(posedge clk);
    cfg_index <= CFG_PRIME;
    cfg_data <= prime;
    @(posedge clk);
    cfg_we <= 1'b0;
    triad_now = triad;
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    s_tuser <= 1'b0;
    s_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TRIAD;
    cfg_data <= 32'd0;
    triad_now = 1'b0;
    src_idle_pct = 38;
    sink_idle_pct = 63;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty message, single extreme bytes, empty items around bytes, every tail bit but 16
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    for (int i = 0; i < 15; i++) send_item(8'(i * 17), 1'b1, i == 14);

    run_random(230);
    load_registers(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    run_random(250);

    src_idle_pct = 63;
    sink_idle_pct = 38;
    load_registers(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    run_random(120);
    load_registers(1'b1, $urandom, $urandom | 32'd1);
    run_random(250);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    load_registers(1'b0, $urandom, 32'd1);
    run_random(170);
    load_registers(1'b0, $urandom, $urandom);
    run_random(250);
    load_registers(1'b1, $urandom, $urandom);
    run_random(260);

    settle();
    if (mismatches == 0) begin
      $display("lane_fnv_rotate_hash32 regression: pass");
    end else begin
      $display("lane_fnv_rotate_hash32 regression: fail");
    end
    $finish;
  end

endmodule
